@@ hw/rtl/r2fft_pkg.sv @@
// Shared constants, codes and types of the radix-2 FFT block.
package r2fft_pkg;

  localparam int LOG2_MAX_POINTS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int TWIDDLE_BITS_DEF    = 18;

  localparam int CFG_DATA_BITS  = 4;
  localparam int CFG_INDEX_BITS = 1;

  localparam real PI_VAL = 3.14159265358979323846;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOG2_POINTS  = 1'b0,
    CFG_INVERSE_MODE = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_BR_RI,
    ST_BR_RR,
    ST_BR_WI,
    ST_BR_WR,
    ST_BF_RQ,
    ST_BF_RP,
    ST_BF_GO,
    ST_BF_WAIT,
    ST_BF_WQ,
    ST_SC_RD,
    ST_SC_WR
  } seq_state_t;

endpackage

@@ hw/rtl/r2fft_if.sv @@
// Valid/ready channel interfaces for the FFT command and result items.
interface r2fft_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (output valid, cmd, sample_real, sample_imag, input ready);
  modport sink (input valid, cmd, sample_real, sample_imag, output ready);
endinterface

interface r2fft_out_if #(
  parameter int DATA_BITS = 26
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] bin_real;
  logic signed [DATA_BITS-1:0] bin_imag;
  logic                        last_bin;
  logic                        frame_ready;

  modport source (output valid, bin_real, bin_imag, last_bin, frame_ready, input ready);
  modport sink (input valid, bin_real, bin_imag, last_bin, frame_ready, output ready);
endinterface

@@ hw/rtl/r2fft_twiddle.sv @@
// Twiddle ROM: rounded cosine and sine of 2*pi*k/N, registered read.
module r2fft_twiddle
  import r2fft_pkg::*;
#(
  parameter int LOG2_MAX_POINTS = LOG2_MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS    = TWIDDLE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic [((LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS-1 : 1)-1:0] addr,
  output logic signed [TWIDDLE_BITS-1:0]                  tw_cos,
  output logic signed [TWIDDLE_BITS-1:0]                  tw_sin
);

  localparam int  KW       = (LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS - 1 : 1;
  localparam int  DEPTH    = 1 << KW;
  localparam int  FRAC     = TWIDDLE_BITS - 1;
  localparam real ANG_STEP = 2.0 * PI_VAL / real'(longint'(1) << LOG2_MAX_POINTS);

  function automatic logic [2*TWIDDLE_BITS*DEPTH-1:0] build_rom();
    logic [2*TWIDDLE_BITS*DEPTH-1:0] rom;
    real    ang;
    real    cv;
    real    sv;
    longint top;
    longint mc;
    longint ms;
    rom = '0;
    top = (longint'(1) << FRAC) - 1;
    for (int k = 0; k < DEPTH; k++) begin
      ang = ANG_STEP * real'(k);
      cv  = $cos(ang);
      sv  = $sin(ang);
      mc  = longint'($floor(((cv < 0.0) ? -cv : cv) * real'(longint'(1) << FRAC) + 0.5));
      ms  = longint'($floor(((sv < 0.0) ? -sv : sv) * real'(longint'(1) << FRAC) + 0.5));
      if (mc > top) mc = top;
      if (ms > top) ms = top;
      if (cv < 0.0) mc = -mc;
      if (sv < 0.0) ms = -ms;
      rom[2*k*TWIDDLE_BITS +: TWIDDLE_BITS]     = TWIDDLE_BITS'(mc);
      rom[(2*k+1)*TWIDDLE_BITS +: TWIDDLE_BITS] = TWIDDLE_BITS'(ms);
    end
    return rom;
  endfunction

  localparam logic [2*TWIDDLE_BITS*DEPTH-1:0] ROM = build_rom();

  always_ff @(posedge clk) begin
    tw_cos <= signed'(ROM[2*TWIDDLE_BITS*int'(addr) +: TWIDDLE_BITS]);
    tw_sin <= signed'(ROM[(2*int'(addr)+1)*TWIDDLE_BITS +: TWIDDLE_BITS]);
  end

endmodule

@@ hw/rtl/r2fft_bfly.sv @@
// Butterfly unit: one shared multiplier, t = W*q over four products, p +/- t saturated.
module r2fft_bfly
  import r2fft_pkg::*;
#(
  parameter int DATA_BITS    = SAMPLE_BITS_DEF + LOG2_MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [DATA_BITS-1:0]    q_re,
  input  logic signed [DATA_BITS-1:0]    q_im,
  input  logic signed [DATA_BITS-1:0]    p_re,
  input  logic signed [DATA_BITS-1:0]    p_im,
  input  logic signed [TWIDDLE_BITS-1:0] tw_cos,
  input  logic signed [TWIDDLE_BITS-1:0] tw_sin,
  output logic                           done,
  output logic signed [DATA_BITS-1:0]    a_re,
  output logic signed [DATA_BITS-1:0]    a_im,
  output logic signed [DATA_BITS-1:0]    b_re,
  output logic signed [DATA_BITS-1:0]    b_im
);

  localparam int PW   = DATA_BITS + TWIDDLE_BITS;
  localparam int FRAC = TWIDDLE_BITS - 1;
  localparam int RW   = PW + 1 - FRAC;
  localparam int SW   = ((RW > DATA_BITS) ? RW : DATA_BITS) + 1;
  localparam logic signed [PW:0]   HALF = (PW+1)'(1) << (FRAC - 1);
  localparam logic signed [SW-1:0] MAXV = {{(SW-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic                           busy_r;
  logic [2:0]                     step_r;
  logic                           done_r;
  logic signed [DATA_BITS-1:0]    qr_r, qi_r, pr_r, pi_r;
  logic signed [TWIDDLE_BITS-1:0] c_r, s_r;
  logic signed [DATA_BITS-1:0]    mul_a;
  logic signed [TWIDDLE_BITS-1:0] mul_b;
  logic signed [PW-1:0]           prod_r;
  logic signed [PW:0]             acc_r;
  logic signed [PW:0]             sum;
  logic signed [RW-1:0]           tr_r, ti_r;
  logic signed [SW-1:0]           ar, ai, br, bi;
  logic signed [DATA_BITS-1:0]    a_re_r, a_im_r, b_re_r, b_im_r;

  function automatic logic signed [DATA_BITS-1:0] sat(input logic signed [SW-1:0] v);
    if (v > MAXV) return MAXV[DATA_BITS-1:0];
    if (v < MINV) return MINV[DATA_BITS-1:0];
    return v[DATA_BITS-1:0];
  endfunction

  always_comb begin
    mul_a = (step_r == 3'd0 || step_r == 3'd3) ? qr_r : qi_r;
    mul_b = (step_r == 3'd0 || step_r == 3'd2) ? c_r : s_r;
    sum   = (step_r == 3'd2) ? acc_r + (PW+1)'(prod_r) : acc_r - (PW+1)'(prod_r);
    ar    = SW'(pr_r) + SW'(tr_r);
    ai    = SW'(pi_r) + SW'(ti_r);
    br    = SW'(pr_r) - SW'(tr_r);
    bi    = SW'(pi_r) - SW'(ti_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && step_r == 3'd5;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr_r <= q_re;
      qi_r <= q_im;
      pr_r <= p_re;
      pi_r <= p_im;
      c_r  <= tw_cos;
      s_r  <= tw_sin;
    end
    prod_r <= PW'(mul_a * mul_b);
    case (step_r)
      3'd1:    acc_r <= (PW+1)'(prod_r) + HALF;
      3'd2:    tr_r  <= RW'(sum >>> FRAC);
      3'd3:    acc_r <= (PW+1)'(prod_r) + HALF;
      3'd4:    ti_r  <= RW'(sum >>> FRAC);
      3'd5: begin
        a_re_r <= sat(ar);
        a_im_r <= sat(ai);
        b_re_r <= sat(br);
        b_im_r <= sat(bi);
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign a_re = a_re_r;
  assign a_im = a_im_r;
  assign b_re = b_re_r;
  assign b_im = b_im_r;

endmodule

@@ hw/rtl/radix2_fft_with_inverse.sv @@
// Radix-2 DIT FFT/IFFT top level: sequencer, work memory, shared butterfly.
//
// Usage: items on in_ch are commands. A load (cmd 0) stores one complex sample;
// the load that completes a frame of 2^L points starts the in-place transform.
// A read (cmd 1) returns the next bin in natural order with last_bin on the
// final one; a read with no finished frame returns zero bins, frame_ready low.
// Every item produces exactly one result item on out_ch, held in an output
// register until out_ch.ready; no new item is taken while a result waits.
// L and inverse mode are written over cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// A load result shows in the cycle after acceptance; a read result passes
// the memory read register and then the output register.
// The frame-completing load then keeps in_ch.ready low for the transform:
// a bit-reversal pass (with conjugation in inverse mode), (n/2)*L butterflies
// on the memory's one read and one write port and the shared multiplier, and
// in inverse mode a rounding scaling pass by 2^-L with conjugation.
// Reset (synchronous, rst_n low) clears counters and the frame flag and sets
// L to the maximum, forward mode. A stalled receiver simply holds the result.
module radix2_fft_with_inverse
  import r2fft_pkg::*;
#(
  parameter int LOG2_MAX_POINTS = LOG2_MAX_POINTS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS    = TWIDDLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  r2fft_in_if.sink                 in_ch,
  r2fft_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DATA_BITS = SAMPLE_BITS + LOG2_MAX_POINTS;
  localparam int NPTS      = 1 << LOG2_MAX_POINTS;
  localparam int AW        = LOG2_MAX_POINTS;
  localparam int CW        = LOG2_MAX_POINTS + 1;
  localparam int LW        = $clog2(LOG2_MAX_POINTS + 1);
  localparam int KW        = (LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS - 1 : 1;
  localparam logic signed [DATA_BITS-1:0] DMAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] DMIN = {1'b1, {(DATA_BITS-1){1'b0}}};

  seq_state_t state_r, state_nxt;
  logic [CW-1:0] lc_r, lc_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic          rv_r, rv_nxt;
  logic [LW-1:0] frame_l_r, frame_l_nxt;
  logic          inv_r, inv_nxt;
  logic [CFG_DATA_BITS-1:0] cfg_l_r;
  logic          cfg_inv_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] stage_r, stage_nxt;

  logic [2*DATA_BITS-1:0] mem [NPTS];
  logic [2*DATA_BITS-1:0] rd_r;
  logic [2*DATA_BITS-1:0] sv_r, sv_nxt;
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [2*DATA_BITS-1:0] wdata;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [DATA_BITS-1:0] bin_re_r, bin_re_nxt, bin_im_r, bin_im_nxt;
  logic                        last_r, last_nxt, fr_r, fr_nxt;

  logic [LW-1:0] l_clamp;
  logic [CW-1:0] n_cur, n_f, lc_inc;
  logic [AW-1:0] i_a, br_a, rev, bj, bp, bq, half_a;
  logic [KW-1:0] tw_addr;
  logic signed [TWIDDLE_BITS-1:0] tw_cos, tw_sin;
  logic          bf_start, bf_done;
  logic signed [DATA_BITS-1:0] a_re, a_im, b_re, b_im;
  logic signed [DATA_BITS-1:0] rd_re, rd_im, sv_re, sv_im;
  logic signed [DATA_BITS:0]   sc_re, sc_im;
  logic signed [DATA_BITS+1:0] sc_half, sc_sum_re, sc_sum_im;
  logic          accept;

  function automatic logic [2*DATA_BITS-1:0] conj(input logic [2*DATA_BITS-1:0] w,
                                                  input logic en);
    logic signed [DATA_BITS-1:0] im;
    im = signed'(w[DATA_BITS-1:0]);
    if (!en) return w;
    return {w[2*DATA_BITS-1:DATA_BITS], (im == DMIN) ? DMAX : -im};
  endfunction

  assign rd_re = signed'(rd_r[2*DATA_BITS-1:DATA_BITS]);
  assign rd_im = signed'(rd_r[DATA_BITS-1:0]);
  assign sv_re = signed'(sv_r[2*DATA_BITS-1:DATA_BITS]);
  assign sv_im = signed'(sv_r[DATA_BITS-1:0]);

  always_comb begin
    if (cfg_l_r == '0) l_clamp = LW'(1);
    else if (32'(cfg_l_r) > LOG2_MAX_POINTS) l_clamp = LW'(LOG2_MAX_POINTS);
    else l_clamp = LW'(cfg_l_r);
    n_cur  = CW'(1) << l_clamp;
    n_f    = CW'(1) << frame_l_r;
    lc_inc = {1'b0, lc_r[AW-1:0]} + CW'(1);
    i_a    = idx_r[AW-1:0];
    for (int b = 0; b < AW; b++) rev[b] = i_a[AW-1-b];
    br_a   = rev >> (LW'(LOG2_MAX_POINTS) - frame_l_r);
    half_a = AW'(1) << (stage_r - LW'(1));
    bj     = i_a & (half_a - AW'(1));
    bp     = ((i_a >> (stage_r - LW'(1))) << stage_r) | bj;
    bq     = bp | half_a;
    tw_addr = KW'(bj << (LW'(LOG2_MAX_POINTS) - stage_r));
    sc_re   = (DATA_BITS+1)'(rd_re);
    sc_im   = -(DATA_BITS+1)'(rd_im);
    sc_half = (DATA_BITS+2)'(1) << (frame_l_r - LW'(1));
    sc_sum_re = ((DATA_BITS+2)'(sc_re) + sc_half) >>> frame_l_r;
    sc_sum_im = ((DATA_BITS+2)'(sc_im) + sc_half) >>> frame_l_r;
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    lc_nxt        = lc_r;
    rc_nxt        = rc_r;
    rv_nxt        = rv_r;
    frame_l_nxt   = frame_l_r;
    inv_nxt       = inv_r;
    idx_nxt       = idx_r;
    stage_nxt     = stage_r;
    sv_nxt        = sv_r;
    we            = 1'b0;
    waddr         = i_a;
    wdata         = rd_r;
    raddr         = i_a;
    bf_start      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    bin_re_nxt    = bin_re_r;
    bin_im_nxt    = bin_im_r;
    last_nxt      = last_r;
    fr_nxt        = fr_r;
    in_ch.ready   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = !out_valid_r;
        if (accept) begin
          if (in_ch.cmd == CMD_LOAD) begin
            we    = 1'b1;
            waddr = lc_r[AW-1:0];
            wdata = {DATA_BITS'(in_ch.sample_real), DATA_BITS'(in_ch.sample_imag)};
            rv_nxt = 1'b0;
            rc_nxt = '0;
            out_valid_nxt = 1'b1;
            bin_re_nxt = '0;
            bin_im_nxt = '0;
            last_nxt   = 1'b0;
            fr_nxt     = 1'b0;
            if (lc_inc >= n_cur) begin
              lc_nxt      = '0;
              frame_l_nxt = l_clamp;
              inv_nxt     = cfg_inv_r;
              idx_nxt     = '0;
              state_nxt   = ST_BR_RI;
            end else begin
              lc_nxt = lc_inc;
            end
          end else if (rv_r) begin
            raddr     = rc_r[AW-1:0];
            state_nxt = ST_RD;
          end else begin
            out_valid_nxt = 1'b1;
            bin_re_nxt = '0;
            bin_im_nxt = '0;
            last_nxt   = 1'b0;
            fr_nxt     = 1'b0;
          end
        end
      end
      ST_RD: begin
        out_valid_nxt = 1'b1;
        bin_re_nxt = rd_re;
        bin_im_nxt = rd_im;
        fr_nxt     = 1'b1;
        last_nxt   = {1'b0, rc_r[AW-1:0]} >= n_f - CW'(1);
        if (last_nxt) begin
          rv_nxt = 1'b0;
          rc_nxt = '0;
        end else begin
          rc_nxt = {1'b0, rc_r[AW-1:0]} + CW'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_BR_RI: begin
        raddr = i_a;
        if (i_a > br_a) begin
          if (idx_r + CW'(1) == n_f) begin
            idx_nxt = '0; stage_nxt = LW'(1); state_nxt = ST_BF_RQ;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else begin
          state_nxt = ST_BR_RR;
        end
      end
      ST_BR_RR: begin
        raddr     = br_a;
        sv_nxt    = rd_r;
        state_nxt = ST_BR_WI;
      end
      ST_BR_WI, ST_BR_WR: begin
        we = 1'b1;
        if (state_r == ST_BR_WI) begin
          waddr = i_a;
          wdata = conj(rd_r, inv_r);
        end else begin
          waddr = br_a;
          wdata = conj(sv_r, inv_r);
        end
        if (state_r == ST_BR_WI && i_a < br_a) begin
          state_nxt = ST_BR_WR;
        end else if (idx_r + CW'(1) == n_f) begin
          idx_nxt = '0; stage_nxt = LW'(1); state_nxt = ST_BF_RQ;
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = ST_BR_RI;
        end
      end
      ST_BF_RQ: begin
        raddr     = bq;
        state_nxt = ST_BF_RP;
      end
      ST_BF_RP: begin
        raddr     = bp;
        sv_nxt    = rd_r;
        state_nxt = ST_BF_GO;
      end
      ST_BF_GO: begin
        bf_start  = 1'b1;
        state_nxt = ST_BF_WAIT;
      end
      ST_BF_WAIT: begin
        if (bf_done) begin
          we        = 1'b1;
          waddr     = bp;
          wdata     = {a_re, a_im};
          state_nxt = ST_BF_WQ;
        end
      end
      ST_BF_WQ: begin
        we    = 1'b1;
        waddr = bq;
        wdata = {b_re, b_im};
        if (idx_r + CW'(1) == (n_f >> 1)) begin
          idx_nxt = '0;
          if (stage_r == frame_l_r) begin
            if (inv_r) begin
              state_nxt = ST_SC_RD;
            end else begin
              rv_nxt = 1'b1; rc_nxt = '0; state_nxt = ST_IDLE;
            end
          end else begin
            stage_nxt = stage_r + LW'(1);
            state_nxt = ST_BF_RQ;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_BF_RQ;
        end
      end
      ST_SC_RD: begin
        raddr     = i_a;
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        we    = 1'b1;
        waddr = i_a;
        wdata = {sc_sum_re[DATA_BITS-1:0], sc_sum_im[DATA_BITS-1:0]};
        if (idx_r + CW'(1) == n_f) begin
          idx_nxt = '0; rv_nxt = 1'b1; rc_nxt = '0; state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = ST_SC_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lc_r        <= '0;
      rc_r        <= '0;
      rv_r        <= 1'b0;
      frame_l_r   <= LW'(LOG2_MAX_POINTS);
      inv_r       <= 1'b0;
      cfg_l_r     <= CFG_DATA_BITS'(LOG2_MAX_POINTS);
      cfg_inv_r   <= 1'b0;
      idx_r       <= '0;
      stage_r     <= LW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      rc_r        <= rc_nxt;
      rv_r        <= rv_nxt;
      frame_l_r   <= frame_l_nxt;
      inv_r       <= inv_nxt;
      idx_r       <= idx_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG2_POINTS:  cfg_l_r   <= cfg_data;
          CFG_INVERSE_MODE: cfg_inv_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sv_r     <= sv_nxt;
    bin_re_r <= bin_re_nxt;
    bin_im_r <= bin_im_nxt;
    last_r   <= last_nxt;
    fr_r     <= fr_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  r2fft_twiddle #(
    .LOG2_MAX_POINTS(LOG2_MAX_POINTS),
    .TWIDDLE_BITS   (TWIDDLE_BITS)
  ) u_twiddle (
    .clk   (clk),
    .addr  (tw_addr),
    .tw_cos(tw_cos),
    .tw_sin(tw_sin)
  );

  r2fft_bfly #(
    .DATA_BITS   (DATA_BITS),
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_bfly (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bf_start),
    .q_re  (sv_re),
    .q_im  (sv_im),
    .p_re  (rd_re),
    .p_im  (rd_im),
    .tw_cos(tw_cos),
    .tw_sin(tw_sin),
    .done  (bf_done),
    .a_re  (a_re),
    .a_im  (a_im),
    .b_re  (b_re),
    .b_im  (b_im)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bin_real    = bin_re_r;
  assign out_ch.bin_imag    = bin_im_r;
  assign out_ch.last_bin    = last_r;
  assign out_ch.frame_ready = fr_r;

endmodule

@@ hw/rtl/r2fft_checker.sv @@
// Port-level assertions for the FFT top level, bound to it.
module r2fft_checker
  import r2fft_pkg::*;
#(
  parameter int DATA_BITS = SAMPLE_BITS_DEF + LOG2_MAX_POINTS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_cmd,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DATA_BITS-1:0] bin_real,
  input logic [DATA_BITS-1:0] bin_imag,
  input logic                 last_bin,
  input logic                 frame_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bin_real) && $stable(bin_imag))
    else $error("result changed while stalled");

  a_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_ready |-> bin_real == '0 && bin_imag == '0 && !last_bin)
    else $error("no-frame result carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous result pending");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("extra result after delivery");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_LOAD |=> out_valid && !frame_ready)
    else $error("load item gave no immediate empty result");

endmodule

bind radix2_fft_with_inverse r2fft_checker #(
  .DATA_BITS(SAMPLE_BITS + LOG2_MAX_POINTS)
) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_cmd     (in_ch.cmd),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .bin_real   (out_ch.bin_real),
  .bin_imag   (out_ch.bin_imag),
  .last_bin   (out_ch.last_bin),
  .frame_ready(out_ch.frame_ready)
);

@@ tb/tb_radix2_fft_with_inverse.sv @@
// Self-checking testbench for the radix-2 FFT/IFFT block with its own bit-exact predictor.
module tb_radix2_fft_with_inverse;
  import r2fft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 1 << LOG2_MAX_POINTS_DEF;
  localparam int DBITS = SAMPLE_BITS_DEF + LOG2_MAX_POINTS_DEF;
  localparam int FRAC = TWIDDLE_BITS_DEF - 1;

  typedef struct {
    logic signed [DBITS-1:0] re;
    logic signed [DBITS-1:0] im;
    logic                    last;
    logic                    rdy;
  } bin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_LOG2_POINTS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  r2fft_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch();
  r2fft_out_if #(.DATA_BITS(DBITS)) out_ch();

  radix2_fft_with_inverse dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint wr[MAXP];
  longint wi[MAXP];
  longint tw_c[MAXP/2];
  longint tw_s[MAXP/2];
  int load_cnt, read_cnt, frame_l2, m_log2, m_inv;
  bit frame_done;
  bin_t bins_q[$];

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic longint sat(longint v);
    longint hi;
    hi = (64'sd1 <<< (DBITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint tw_q(real v);
    real m;
    longint r;
    m = (v < 0.0 ? -v : v) * real'(64'd1 << FRAC);
    r = longint'($floor(m + 0.5));
    if (r > (64'sd1 <<< FRAC) - 1) r = (64'sd1 <<< FRAC) - 1;
    return v < 0.0 ? -r : r;
  endfunction

  task automatic run_fft(int l2, bit inv);
    int n, r, half;
    longint c, s, qr, qi, tr, ti, pr, pi, t;
    n = 1 << l2;
    if (inv) for (int i = 0; i < n; i++) wi[i] = sat(-wi[i]);
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < l2; b++) r = (r << 1) | ((i >> b) & 1);
      if (i < r) begin
        t = wr[i]; wr[i] = wr[r]; wr[r] = t;
        t = wi[i]; wi[i] = wi[r]; wi[r] = t;
      end
    end
    for (int l = 1; l <= l2; l++) begin
      half = 1 << (l - 1);
      for (int j = 0; j < half; j++) begin
        c = tw_c[j << (LOG2_MAX_POINTS_DEF - l)];
        s = tw_s[j << (LOG2_MAX_POINTS_DEF - l)];
        for (int i = j; i < n; i += 2 * half) begin
          qr = wr[i + half]; qi = wi[i + half];
          tr = rnd_shift(qr * c + qi * s, FRAC);
          ti = rnd_shift(qi * c - qr * s, FRAC);
          pr = wr[i]; pi = wi[i];
          wr[i] = sat(pr + tr); wi[i] = sat(pi + ti);
          wr[i + half] = sat(pr - tr); wi[i + half] = sat(pi - ti);
        end
      end
    end
    if (inv) for (int i = 0; i < n; i++) begin
      wr[i] = sat(rnd_shift(wr[i], l2));
      wi[i] = sat(rnd_shift(-wi[i], l2));
    end
  endtask

  task automatic predict_bin(logic cmd, logic signed [15:0] sr, logic signed [15:0] si);
    bin_t b;
    int l2, idx;
    b = '{re: '0, im: '0, last: 1'b0, rdy: 1'b0};
    if (cmd == CMD_LOAD) begin
      l2 = m_log2 < 1 ? 1 : (m_log2 > LOG2_MAX_POINTS_DEF ? LOG2_MAX_POINTS_DEF : m_log2);
      frame_done = 0;
      read_cnt = 0;
      load_cnt &= MAXP - 1;
      wr[load_cnt] = sr;
      wi[load_cnt] = si;
      load_cnt++;
      if (load_cnt >= (1 << l2)) begin
        run_fft(l2, m_inv != 0);
        frame_l2 = l2;
        load_cnt = 0;
        frame_done = 1;
      end
    end else if (frame_done) begin
      idx = read_cnt & (MAXP - 1);
      b.re = wr[idx][DBITS-1:0];
      b.im = wi[idx][DBITS-1:0];
      b.last = idx >= (1 << frame_l2) - 1;
      b.rdy = 1'b1;
      if (b.last) begin
        frame_done = 0;
        read_cnt = 0;
      end else begin
        read_cnt = idx + 1;
      end
    end
    bins_q.push_back(b);
  endtask

  task automatic send_item(logic cmd, logic signed [15:0] sr, logic signed [15:0] si);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.sample_real <= sr;
    in_ch.sample_imag <= si;
    do @(posedge clk); while (!in_ch.ready);
    predict_bin(cmd, sr, si);
  endtask

  // wait for all bins and the end of any transform, then write both registers
  task automatic set_mode(logic [3:0] l2, logic inv);
    in_ch.valid <= 1'b0;
    wait (bins_q.size() == 0);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOG2_POINTS;
    cfg_data <= l2;
    @(posedge clk);
    m_log2 = l2;
    cfg_index <= CFG_INVERSE_MODE;
    cfg_data <= {3'b000, inv};
    @(posedge clk);
    m_inv = inv;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_frame(int n);
    for (int i = 0; i < n; i++) send_item(CMD_LOAD, rand_sample(), rand_sample());
  endtask

  task automatic read_bins(int n);
    for (int i = 0; i < n; i++) send_item(CMD_READ, $urandom, $urandom);
  endtask

  task automatic report(string what, bin_t got, bin_t exp_b);
    $display("mismatch %s: got %0d %0d %0b %0b exp %0d %0d %0b %0b", what,
             got.re, got.im, got.last, got.rdy, exp_b.re, exp_b.im, exp_b.last, exp_b.rdy);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_t got, exp_b;
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{re: out_ch.bin_real, im: out_ch.bin_imag,
              last: out_ch.last_bin, rdy: out_ch.frame_ready};
      if (bins_q.size() == 0) begin
        exp_b = '{re: 'x, im: 'x, last: 1'bx, rdy: 1'bx};
        report("unexpected item", got, exp_b);
      end else begin
        exp_b = bins_q.pop_front();
        if (got.re !== exp_b.re || got.im !== exp_b.im || got.last !== exp_b.last ||
            got.rdy !== exp_b.rdy)
          report("bin", got, exp_b);
      end
    end
  end

  task automatic test_directed();
    send_item(CMD_READ, 16'sh7fff, 16'sh8000);
    set_mode(4'd2, 1'b0);
    send_item(CMD_LOAD, 16'sh7fff, 16'sh8000);
    send_item(CMD_LOAD, 16'sh8000, 16'sh7fff);
    send_item(CMD_LOAD, 16'sh0000, 16'sh0000);
    send_item(CMD_LOAD, -16'sd1, 16'sd1);
    read_bins(5);
    // new frame drops an unread one
    set_mode(4'd1, 1'b0);
    load_frame(2);
    read_bins(1);
    load_frame(2);
    read_bins(3);
  endtask

  task automatic test_config();
    set_mode(4'd3, 1'b1);
    load_frame(8);
    read_bins(9);
    set_mode(4'd0, 1'b1);
    load_frame(2);
    read_bins(3);
    // length shrunk in mid-frame, starting from an over-range length
    set_mode(4'd15, 1'b0);
    load_frame(5);
    set_mode(4'd2, 1'b0);
    load_frame(1);
    read_bins(4);
  endtask

  task automatic test_random(int items);
    int cnt, l2, n, k;
    cnt = 0;
    while (cnt < items) begin
      k = $urandom_range(9);
      if (k == 0) begin
        send_item($urandom, rand_sample(), rand_sample());
        cnt++;
      end else begin
        l2 = ($urandom_range(4) == 0) ? $urandom_range(7, 5) : $urandom_range(4, 1);
        n = 1 << l2;
        if (k == 1 || m_log2 != l2 || $urandom_range(3) == 0)
          set_mode(l2, $urandom);
        if (k == 1) begin
          // broken frame: partial load, then reads that find no finished frame
          load_frame($urandom_range(n - 1, 1));
          read_bins($urandom_range(2));
          cnt += 3;
        end else begin
          load_frame(n);
          read_bins(n + ($urandom_range(3) == 0));
          cnt += 2 * n;
        end
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.sample_real = '0;
    in_ch.sample_imag = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < MAXP / 2; k++) begin
      tw_c[k] = tw_q($cos(2.0 * PI_VAL * k / MAXP));
      tw_s[k] = tw_q($sin(2.0 * PI_VAL * k / MAXP));
    end
    for (int i = 0; i < MAXP; i++) begin
      wr[i] = 0;
      wi[i] = 0;
    end
    load_cnt = 0; read_cnt = 0; frame_done = 0;
    frame_l2 = LOG2_MAX_POINTS_DEF; m_log2 = 10; m_inv = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 36; recv_idle = 69;
    test_directed();
    test_config();
    test_random(100);
    send_idle = 69; recv_idle = 36;
    test_random(100);
    send_idle = 0; recv_idle = 0;
    test_random(100);
    in_ch.valid <= 1'b0;
    wait (bins_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_if.sv
hw/rtl/r2fft_twiddle.sv
hw/rtl/r2fft_bfly.sv
hw/rtl/radix2_fft_with_inverse.sv
hw/rtl/r2fft_checker.sv
tb/tb_radix2_fft_with_inverse.sv
